// ===== rtl/arp_resolve_and_reply_defines.svh =====
// Assertion macros shared by the ARP engine modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ARP_RESOLVE_AND_REPLY_DEFINES_SVH
`define ARP_RESOLVE_AND_REPLY_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ARR_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a consequence holds in the same cycle as its cause.
`define ARR_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/arr_pkg.sv =====
`timescale 1ns / 1ps
package arr_pkg;

  localparam int PayloadBytes = 28;
  localparam int IdxW         = $clog2(PayloadBytes);
  localparam int CmdFifoDepth = 2;

  localparam logic [7:0]  HwTypeEtherLow = 8'h01;
  localparam logic [15:0] ProtoIpv4      = 16'h0800;
  localparam logic [7:0]  HwAddrLen      = 8'd6;
  localparam logic [7:0]  ProtoAddrLen   = 8'd4;
  localparam logic [7:0]  ArpOpRequest   = 8'h01;
  localparam logic [7:0]  ArpOpReply     = 8'h02;
  localparam logic [47:0] BcastMac       = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] NoGateway      = 32'h0000_0000;

  typedef enum logic [1:0] {
    KindPacket  = 2'd0,
    KindResolve = 2'd1,
    KindCheck   = 2'd2
  } req_kind_e;

  typedef enum logic [1:0] {
    RegLocalIp    = 2'd0,
    RegSubnetMask = 2'd1,
    RegGatewayIp  = 2'd2,
    RegLocalMac   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        tx_ready;
    logic        short_packet;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [47:0] eth_dest_mac;
    logic        last;
    logic        done_res;
    logic        packet_consumed;
    logic        resolved;
    logic [47:0] resolved_mac;
  } result_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [47:0] local_mac;
  } cfg_t;

  // One command from the classifier to the transmit side. For an ARP frame the
  // mac field is both the Ethernet destination and the target hardware address
  // and ip is the already routed target IP; for a single status result the mac
  // field carries the resolved MAC.
  typedef struct packed {
    logic        is_arp;
    logic        is_reply;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        done;
    logic        cons;
    logic        res;
  } cmd_t;

  function automatic logic [7:0] arp_byte(logic [IdxW-1:0] idx, cmd_t c, cfg_t cfg);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd1:  b = HwTypeEtherLow;
      5'd2:  b = ProtoIpv4[15:8];
      5'd3:  b = ProtoIpv4[7:0];
      5'd4:  b = HwAddrLen;
      5'd5:  b = ProtoAddrLen;
      5'd7:  b = c.is_reply ? ArpOpReply : ArpOpRequest;
      5'd8:  b = cfg.local_mac[47:40];
      5'd9:  b = cfg.local_mac[39:32];
      5'd10: b = cfg.local_mac[31:24];
      5'd11: b = cfg.local_mac[23:16];
      5'd12: b = cfg.local_mac[15:8];
      5'd13: b = cfg.local_mac[7:0];
      5'd14: b = cfg.local_ip[31:24];
      5'd15: b = cfg.local_ip[23:16];
      5'd16: b = cfg.local_ip[15:8];
      5'd17: b = cfg.local_ip[7:0];
      5'd18: b = c.mac[47:40];
      5'd19: b = c.mac[39:32];
      5'd20: b = c.mac[31:24];
      5'd21: b = c.mac[23:16];
      5'd22: b = c.mac[15:8];
      5'd23: b = c.mac[7:0];
      5'd24: b = c.ip[31:24];
      5'd25: b = c.ip[23:16];
      5'd26: b = c.ip[15:8];
      5'd27: b = c.ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/arr_front.sv =====
`timescale 1ns / 1ps
module arr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arr_pkg::cfg_t     cfg_i,
  input  arr_pkg::in_item_t item_i,
  input  logic            accept_i,
  output arr_pkg::cmd_t     cmd_o
);
  import arr_pkg::*;

  logic        pending_q, pending_d;
  logic [47:0] remote_mac_q, remote_mac_d;
  logic [31:0] remote_ip_q, remote_ip_d;
  logic [47:0] resp_mac_q, resp_mac_d;
  logic [31:0] resp_ip_q, resp_ip_d;
  logic [31:0] src_ip;
  logic        hdr_ok;
  logic        check_ok;
  logic        off_subnet;
  cmd_t        cmd;

  assign hdr_ok = (item_i.hw_type[7:0] == HwTypeEtherLow) &&
                  (item_i.proto_type == ProtoIpv4) &&
                  (item_i.hw_len == HwAddrLen) &&
                  (item_i.proto_len == ProtoAddrLen) &&
                  (item_i.target_ip == cfg_i.local_ip);

  assign check_ok = (resp_ip_q == item_i.query_ip) ||
                    ((cfg_i.gateway_ip != NoGateway) && (resp_ip_q == cfg_i.gateway_ip));

  always_comb begin
    cmd          = '0;
    src_ip       = item_i.query_ip;
    pending_d    = pending_q;
    remote_mac_d = remote_mac_q;
    remote_ip_d  = remote_ip_q;
    resp_mac_d   = resp_mac_q;
    resp_ip_d    = resp_ip_q;
    unique case (req_kind_e'(item_i.req_type))
      KindPacket: begin
        if (pending_q) begin
          // The held reply goes first; the packet itself is not read.
          src_ip = remote_ip_q;
          if (item_i.tx_ready) begin
            cmd.is_arp   = 1'b1;
            cmd.is_reply = 1'b1;
            cmd.mac      = remote_mac_q;
            cmd.done     = 1'b1;
            pending_d    = 1'b0;
          end
        end else if (item_i.short_packet) begin
          cmd.done = 1'b1;
        end else if (!hdr_ok) begin
          cmd.done = 1'b1;
          cmd.cons = 1'b1;
        end else if (item_i.opcode[7:0] == ArpOpRequest) begin
          remote_mac_d = item_i.sender_mac;
          remote_ip_d  = item_i.sender_ip;
          src_ip       = item_i.sender_ip;
          cmd.cons     = 1'b1;
          if (item_i.tx_ready) begin
            cmd.is_arp   = 1'b1;
            cmd.is_reply = 1'b1;
            cmd.mac      = item_i.sender_mac;
            cmd.done     = 1'b1;
          end else begin
            pending_d = 1'b1;
          end
        end else begin
          cmd.done = 1'b1;
          cmd.cons = 1'b1;
          if (item_i.opcode[7:0] == ArpOpReply) begin
            resp_mac_d = item_i.sender_mac;
            resp_ip_d  = item_i.sender_ip;
          end
        end
      end
      KindResolve: begin
        if (item_i.tx_ready) begin
          cmd.is_arp = 1'b1;
          cmd.mac    = BcastMac;
          cmd.done   = 1'b1;
          resp_ip_d  = '0;
        end
      end
      KindCheck: begin
        cmd.done = 1'b1;
        if (check_ok) begin
          cmd.res = 1'b1;
          cmd.mac = resp_mac_q;
        end
      end
      default: begin
        cmd.done = 1'b1;
      end
    endcase
    off_subnet = |((cfg_i.local_ip ^ src_ip) & cfg_i.subnet_mask);
    cmd.ip     = off_subnet ? cfg_i.gateway_ip : src_ip;
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      resp_mac_q <= '0;
      resp_ip_q <= '0;
    end else if (accept_i) begin
      pending_q <= pending_d;
      resp_mac_q <= resp_mac_d;
      resp_ip_q <= resp_ip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      remote_mac_q <= remote_mac_d;
      remote_ip_q <= remote_ip_d;
    end
  end

endmodule

// ===== rtl/arr_cmd_fifo.sv =====
`timescale 1ns / 1ps
`include "arp_resolve_and_reply_defines.svh"
module arr_cmd_fifo #(
  parameter int Depth = arr_pkg::CmdFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  arr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output arr_pkg::cmd_t cmd_o
);
  import arr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ARR_ASSERT(a_count_bound, count_q <= CntW'(Depth), "command queue overfilled")
  `ARR_ASSERT_IMPLIES(a_no_push_full, push_i, !full_o, "push into a full command queue")
  `ARR_ASSERT_IMPLIES(a_no_pop_empty, pop_i, valid_o, "pop from an empty command queue")

endmodule

// ===== rtl/arr_back.sv =====
`timescale 1ns / 1ps
`include "arp_resolve_and_reply_defines.svh"
module arr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arr_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  arr_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output arr_pkg::result_t result_o
);
  import arr_pkg::*;

  logic [IdxW-1:0] idx_q;
  result_t         out_q;
  logic            out_valid_q;
  result_t         res;
  logic            advance;
  logic            produce;

  always_comb begin
    res = '0;
    if (cmd_i.is_arp) begin
      res.tx_valid        = 1'b1;
      res.tx_byte         = arp_byte(idx_q, cmd_i, cfg_i);
      res.eth_dest_mac    = cmd_i.mac;
      res.last            = (idx_q == IdxW'(PayloadBytes - 1));
      res.done_res        = 1'b1;
      res.packet_consumed = cmd_i.cons;
    end else begin
      res.last            = 1'b1;
      res.done_res        = cmd_i.done;
      res.packet_consumed = cmd_i.cons;
      res.resolved        = cmd_i.res;
      res.resolved_mac    = cmd_i.mac;
    end
  end

  assign advance   = !out_valid_q || pop_i;
  assign produce   = advance && cmd_valid_i;
  assign cmd_pop_o = produce && res.last;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
      idx_q       <= res.last ? '0 : idx_q + 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `ARR_ASSERT(a_idx_range, idx_q < IdxW'(PayloadBytes), "byte index past frame end")
  `ARR_ASSERT_IMPLIES(a_single_at_start, cmd_valid_i && !cmd_i.is_arp, idx_q == '0,
                      "status command seen mid-frame")
  `ARR_ASSERT_IMPLIES(a_pop_needs_produce, cmd_pop_o, produce && res.last,
                      "command retired without its last result")

endmodule

// ===== rtl/arp_resolve_and_reply.sv =====
`timescale 1ns / 1ps
// A taken request passes through the command queue and the output register before its result
// shows. A request that sends an ARP frame yields its 28 payload bytes; any other request
// yields one status result. A two-entry command queue sits between the classifier and the
// byte sequencer. Reset (rst_ni low, asynchronous) clears the registers, the pending reply
// flag, the last response and both queues; no clearing pass.
module arp_resolve_and_reply #(
  parameter int CmdDepth = arr_pkg::CmdFifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request side, queue-like: taken when push is high and full is low.
  input  logic              push,
  output logic              full,
  input  arr_pkg::in_item_t in_item_i,
  // Result side, queue-like: the oldest result is shown while empty is low.
  output logic              empty,
  input  logic              pop,
  output arr_pkg::result_t  result_o,
  // Register write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [47:0]       cfg_data_i
);
  import arr_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic accept;
  logic queue_valid;
  logic queue_pop;

  // Register writes are always taken. Software must change them only while the block is
  // idle, which the block itself does not enforce, so the front and back read them directly.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegLocalIp:    cfg_q.local_ip <= cfg_data_i[31:0];
        RegSubnetMask: cfg_q.subnet_mask <= cfg_data_i[31:0];
        RegGatewayIp:  cfg_q.gateway_ip <= cfg_data_i[31:0];
        RegLocalMac:   cfg_q.local_mac <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A request is taken whenever the command queue has room. The front part
  // classifies it in the same cycle, updates the responder state (pending
  // reply, remote peer, last response) and turns it into one command.
  assign accept = push && !full;

  arr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (in_item_i),
    .accept_i (accept),
    .cmd_o    (front_cmd)
  );

  // The command queue lets the classifier keep taking requests while the
  // back part is still streaming a 28-byte frame.
  arr_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The back part expands each command into its results: one status result,
  // or the ARP payload a byte per cycle while results are popped. Its output
  // register holds the shown result and is refilled in the same cycle it is popped.
  arr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== tb/arp_resolve_and_reply_tb.sv =====
`timescale 1ns / 1ps
module arp_resolve_and_reply_tb;
  import arr_pkg::*;

  // Request kind that the block does not know; it must answer with a plain status.
  localparam logic [1:0] KindUnused = 2'd3;
  // Opcode low byte that is neither request nor reply.
  localparam logic [7:0] ArpOpUnknown = 8'h03;

  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned RandomPerPhase = 71;
  localparam int unsigned MaxPrinted     = 100;

  // Settings of the first phase, which the directed rows are written against.
  localparam logic [31:0] LocalIp1 = 32'hC0A8_0164;
  localparam logic [31:0] Mask1    = 32'hFFFF_FF00;
  localparam logic [31:0] Gw1      = 32'hC0A8_0101;
  localparam logic [47:0] Mac1     = 48'h0200_5E10_2030;

  localparam logic [47:0] PeerMacA = 48'h001B_213C_4D5E;
  localparam logic [31:0] PeerIpA  = 32'hC0A8_0107;
  localparam logic [47:0] PeerMacB = 48'h0011_2233_4455;
  localparam logic [31:0] PeerIpB  = 32'hC0A8_0123;
  localparam logic [47:0] RespMac  = 48'hA45E_6001_0203;
  localparam logic [31:0] RespIp   = 32'hC0A8_0109;
  localparam logic [47:0] GwMac    = 48'h0000_0C9F_F001;

  // Receiver stall patterns; each one runs for a random stretch of cycles.
  typedef enum logic [1:0] {
    SinkFree,
    SinkCoin,
    SinkSlow,
    SinkBeat
  } sink_mode_e;

  // One line of the directed table. Where typed is set, want is the one expected
  // status result; otherwise the expectation comes from the predictor.
  typedef struct {
    in_item_t item;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    in_item_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegLocalIp;
  logic [47:0] cfg_data_i  = '0;

  // Shadow copy of the block's registers and state, kept by the predictor.
  logic [31:0] cfg_local_ip    = '0;
  logic [31:0] cfg_subnet_mask = '0;
  logic [31:0] cfg_gateway_ip  = '0;
  logic [47:0] cfg_local_mac   = '0;
  logic        st_reply_pending = 1'b0;
  logic [47:0] st_peer_mac      = '0;
  logic [31:0] st_peer_ip       = '0;
  logic [47:0] st_resp_mac      = '0;
  logic [31:0] st_resp_ip       = '0;

  result_t     step_results_q[$];   // results of the request just taken
  result_t     arp_expected_q[$];   // results still owed by the block
  stim_row_t   directed_rows[$];

  // Recently answered sender addresses, so that resolve checks often hit.
  logic [31:0] answered_ips[4] = '{default: '0};
  int unsigned answered_wr = 0;

  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left   = 0;
  bit          hold_req     = 1'b0;

  arp_resolve_and_reply i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    end
  endtask

  // A single status result, the answer to every request that sends no frame.
  function automatic result_t status_res(input logic done, input logic cons,
                                         input logic res, input logic [47:0] mac);
    result_t r;
    r = '0;
    r.last            = 1'b1;
    r.done_res        = done;
    r.packet_consumed = cons;
    r.resolved        = res;
    r.resolved_mac    = mac;
    return r;
  endfunction

  // Queues the 28 payload bytes of an outgoing ARP frame in wire order. The
  // target MAC and the Ethernet destination are the same address for both
  // replies and broadcast requests. An address off our subnet goes to the gateway.
  function automatic void push_frame(input logic [7:0] op, input logic [47:0] peer_mac,
                                     input logic [31:0] ip, input logic cons);
    logic [31:0]  routed_ip;
    logic [223:0] payload;
    result_t      r;
    routed_ip = (((cfg_local_ip ^ ip) & cfg_subnet_mask) != '0) ? cfg_gateway_ip : ip;
    payload = {8'h00, HwTypeEtherLow, ProtoIpv4, HwAddrLen, ProtoAddrLen, 8'h00, op,
               cfg_local_mac, cfg_local_ip, peer_mac, routed_ip};
    for (int i = 0; i < PayloadBytes; i++) begin
      r                 = '0;
      r.tx_valid        = 1'b1;
      r.tx_byte         = payload[223 - 8 * i -: 8];
      r.eth_dest_mac    = peer_mac;
      r.last            = (i == PayloadBytes - 1);
      r.done_res        = 1'b1;
      r.packet_consumed = cons;
      step_results_q.push_back(r);
    end
  endfunction

  function automatic void send_pending_reply(input logic cons);
    st_reply_pending = 1'b0;
    push_frame(ArpOpReply, st_peer_mac, st_peer_ip, cons);
  endfunction

  // Works out what the block answers to one accepted request and moves the
  // shadow state along with it.
  function automatic void predict_arp(input in_item_t it);
    logic hit;
    step_results_q.delete();
    case (it.req_type)
      KindPacket: begin
        if (st_reply_pending) begin
          // A held reply blocks the receive path; the packet itself is not read.
          if (!it.tx_ready) begin
            step_results_q.push_back(status_res(1'b0, 1'b0, 1'b0, '0));
          end else begin
            send_pending_reply(1'b0);
          end
        end else if (it.short_packet) begin
          step_results_q.push_back(status_res(1'b1, 1'b0, 1'b0, '0));
        end else if (it.hw_type[7:0] != HwTypeEtherLow || it.proto_type != ProtoIpv4 ||
                     it.hw_len != HwAddrLen || it.proto_len != ProtoAddrLen ||
                     it.target_ip != cfg_local_ip) begin
          step_results_q.push_back(status_res(1'b1, 1'b1, 1'b0, '0));
        end else if (it.opcode[7:0] == ArpOpRequest) begin
          st_peer_mac      = it.sender_mac;
          st_peer_ip       = it.sender_ip;
          st_reply_pending = 1'b1;
          if (!it.tx_ready) begin
            step_results_q.push_back(status_res(1'b0, 1'b1, 1'b0, '0));
          end else begin
            send_pending_reply(1'b1);
          end
        end else begin
          if (it.opcode[7:0] == ArpOpReply) begin
            st_resp_mac = it.sender_mac;
            st_resp_ip  = it.sender_ip;
          end
          step_results_q.push_back(status_res(1'b1, 1'b1, 1'b0, '0));
        end
      end
      KindResolve: begin
        if (!it.tx_ready) begin
          step_results_q.push_back(status_res(1'b0, 1'b0, 1'b0, '0));
        end else begin
          st_resp_ip = '0;
          push_frame(ArpOpRequest, BcastMac, it.query_ip, 1'b0);
        end
      end
      KindCheck: begin
        hit = (st_resp_ip == it.query_ip) ||
              (cfg_gateway_ip != NoGateway && st_resp_ip == cfg_gateway_ip);
        step_results_q.push_back(status_res(1'b1, 1'b0, hit, hit ? st_resp_mac : '0));
      end
      default: begin
        step_results_q.push_back(status_res(1'b1, 1'b0, 1'b0, '0));
      end
    endcase
  endfunction

  // A well-formed received packet addressed as given.
  function automatic in_item_t rx_packet(input logic ready, input logic [15:0] op,
                                         input logic [47:0] smac, input logic [31:0] sip,
                                         input logic [31:0] tip);
    in_item_t it;
    it            = '0;
    it.req_type   = KindPacket;
    it.tx_ready   = ready;
    it.hw_type    = {8'h00, HwTypeEtherLow};
    it.proto_type = ProtoIpv4;
    it.hw_len     = HwAddrLen;
    it.proto_len  = ProtoAddrLen;
    it.opcode     = op;
    it.sender_mac = smac;
    it.sender_ip  = sip;
    it.target_ip  = tip;
    return it;
  endfunction

  function automatic in_item_t query(input logic [1:0] kind, input logic ready,
                                     input logic [31:0] qip);
    in_item_t it;
    it          = '0;
    it.req_type = kind;
    it.tx_ready = ready;
    it.query_ip = qip;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input result_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Random request. Kind, opcode, addresses and the hw_type high byte start random;
  // most requests are then shaped into well-formed traffic that reaches the
  // reply, response and resolve paths, and the rest stays broken or noisy.
  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned pick;
    logic [31:0] spread;
    it.req_type     = 2'($urandom);
    it.tx_ready     = ($urandom_range(0, 3) != 0);
    it.short_packet = 1'b0;
    it.hw_type      = {8'($urandom), HwTypeEtherLow};
    it.proto_type   = ProtoIpv4;
    it.hw_len       = HwAddrLen;
    it.proto_len    = ProtoAddrLen;
    it.opcode       = 16'($urandom);
    it.sender_mac   = {16'($urandom), 32'($urandom)};
    it.sender_ip    = $urandom;
    it.target_ip    = cfg_local_ip;
    it.query_ip     = $urandom;
    spread          = $urandom;
    pick            = $urandom_range(0, 99);
    if (pick < 30) begin
      it.req_type   = KindPacket;
      it.opcode[7:0] = ArpOpRequest;
    end else if (pick < 50) begin
      it.req_type   = KindPacket;
      it.opcode[7:0] = ArpOpReply;
      if ($urandom_range(0, 3) == 0) it.sender_ip = cfg_gateway_ip;
      answered_ips[answered_wr % 4] = it.sender_ip;
      answered_wr++;
    end else if (pick < 65) begin
      it.req_type = KindResolve;
      if ($urandom_range(0, 1) == 0) begin
        it.query_ip = (cfg_local_ip & cfg_subnet_mask) | (spread & ~cfg_subnet_mask);
      end
    end else if (pick < 80) begin
      it.req_type = KindCheck;
      case ($urandom_range(0, 5))
        0, 1, 2: it.query_ip = answered_ips[$urandom_range(0, 3)];
        3:       it.query_ip = cfg_gateway_ip;
        4:       it.query_ip = '0;
        default: ;
      endcase
    end else if (pick < 92) begin
      // A received packet with one thing wrong with it.
      it.req_type = KindPacket;
      case ($urandom_range(0, 6))
        0:       it.short_packet = 1'b1;
        1:       it.hw_type      = 16'($urandom);
        2:       it.proto_type   = 16'($urandom);
        3:       it.hw_len       = 8'($urandom);
        4:       it.proto_len    = 8'($urandom);
        5:       it.target_ip    = $urandom;
        default: it.opcode       = 16'($urandom);
      endcase
    end else begin
      it.short_packet = 1'($urandom);
      it.proto_type   = 16'($urandom);
      it.hw_len       = 8'($urandom);
      it.proto_len    = 8'($urandom);
      it.target_ip    = ($urandom_range(0, 1) == 0) ? cfg_local_ip : $urandom;
    end
    return it;
  endfunction

  // Offers one request and returns at the clock edge that takes it. The sender
  // runs in bursts; between bursts push drops for a random gap. Called at a
  // rising edge.
  task automatic send_request(input in_item_t it, input bit typed, input result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    push      <= 1'b1;
    in_item_i <= it;
    // Handshake inputs are sampled mid-cycle, where they are stable.
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
    predict_arp(it);
    if (typed) begin
      arp_expected_q.push_back(want);
    end else begin
      foreach (step_results_q[i]) arp_expected_q.push_back(step_results_q[i]);
    end
  endtask

  // Stops offering requests and waits until every expected result is out and the block is idle.
  task automatic drain_results();
    push <= 1'b0;
    while (arp_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Called at a rising edge; valid stays high across back-to-back writes.
  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      RegLocalIp:    cfg_local_ip    = data[31:0];
      RegSubnetMask: cfg_subnet_mask = data[31:0];
      RegGatewayIp:  cfg_gateway_ip  = data[31:0];
      default:       cfg_local_mac   = data;
    endcase
  endtask

  // The unused top bits of the 32-bit registers are filled with noise; the
  // block must ignore them.
  task automatic apply_config(input logic [31:0] ip, input logic [31:0] mask,
                              input logic [31:0] gw, input logic [47:0] mac);
    write_reg(RegLocalIp,    {16'($urandom), ip});
    write_reg(RegSubnetMask, {16'($urandom), mask});
    write_reg(RegGatewayIp,  {16'($urandom), gw});
    write_reg(RegLocalMac,   mac);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: checks each accepted result against the oldest expectation
  // and keeps a watchdog on cycles in which no handshake of any kind happens.
  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WatchdogLimit) begin
          $display("%0t ns: no handshake for %0d cycles", $time, stall_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
      if (pop && !empty) begin
        if (arp_expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(result_o.tx_byte), '0);
        end else begin
          want = arp_expected_q.pop_front();
          if (result_o.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 64'(result_o.tx_valid), 64'(want.tx_valid));
          if (result_o.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", 64'(result_o.tx_byte), 64'(want.tx_byte));
          if (result_o.eth_dest_mac !== want.eth_dest_mac)
            report_mismatch("eth_dest_mac", 64'(result_o.eth_dest_mac),
                            64'(want.eth_dest_mac));
          if (result_o.last !== want.last)
            report_mismatch("last", 64'(result_o.last), 64'(want.last));
          if (result_o.done_res !== want.done_res)
            report_mismatch("done_res", 64'(result_o.done_res), 64'(want.done_res));
          if (result_o.packet_consumed !== want.packet_consumed)
            report_mismatch("packet_consumed", 64'(result_o.packet_consumed),
                            64'(want.packet_consumed));
          if (result_o.resolved !== want.resolved)
            report_mismatch("resolved", 64'(result_o.resolved), 64'(want.resolved));
          if (result_o.resolved_mac !== want.resolved_mac)
            report_mismatch("resolved_mac", 64'(result_o.resolved_mac),
                            64'(want.resolved_mac));
        end
      end
    end
  end

  // Receiver: switches between stall patterns at random, and on request holds
  // pop low for a long stretch so that the block backs up and raises full.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned beat;
    mode      = SinkFree;
    mode_left = 0;
    hold_left = 0;
    beat      = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          SinkFree: pop <= 1'b1;
          SinkCoin: pop <= 1'($urandom);
          SinkSlow: pop <= ($urandom_range(0, 7) == 0);
          default: begin
            beat++;
            pop <= (beat % 3) != 0;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    it = '0;

    // Directed table. The first two rows run with the registers as reset
    // leaves them; the first phase settings are written before the third row.
    add_row(query(KindCheck, 1'b1, '0), 1'b1, status_res(1'b1, 1'b0, 1'b1, '0));
    it          = '1;
    it.req_type = KindUnused;
    add_row(it, 1'b1, status_res(1'b1, 1'b0, 1'b0, '0));
    // A packet that ran out early is left alone, not consumed.
    it              = rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1);
    it.short_packet = 1'b1;
    add_row(it, 1'b1, status_res(1'b1, 1'b0, 1'b0, '0));
    // Header faults and a foreign target: the packet is dropped.
    it         = rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1);
    it.hw_type = 16'h0002;
    add_row(it, 1'b1, status_res(1'b1, 1'b1, 1'b0, '0));
    it            = rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1);
    it.hw_type    = 16'hFF01;
    it.proto_type = 16'h0806;
    add_row(it, 1'b1, status_res(1'b1, 1'b1, 1'b0, '0));
    it        = rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1);
    it.hw_len = 8'hFF;
    add_row(it, 1'b1, status_res(1'b1, 1'b1, 1'b0, '0));
    it           = rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1);
    it.proto_len = 8'h00;
    add_row(it, 1'b1, status_res(1'b1, 1'b1, 1'b0, '0));
    add_row(rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, '0), 1'b1,
            status_res(1'b1, 1'b1, 1'b0, '0));
    // An opcode that is neither request nor reply is consumed and ignored.
    add_row(rx_packet(1'b1, {8'h00, ArpOpUnknown}, PeerMacA, PeerIpA, LocalIp1), 1'b1,
            status_res(1'b1, 1'b1, 1'b0, '0));
    // A response is stored, and a check for its address then resolves.
    add_row(rx_packet(1'b1, {8'h00, ArpOpReply}, RespMac, RespIp, LocalIp1), 1'b1,
            status_res(1'b1, 1'b1, 1'b0, '0));
    add_row(query(KindCheck, 1'b0, RespIp), 1'b1, status_res(1'b1, 1'b0, 1'b1, RespMac));
    add_row(query(KindCheck, 1'b1, 32'hC0A8_01FE), 1'b1,
            status_res(1'b1, 1'b0, 1'b0, '0));
    // A request for us is answered at once.
    add_row(rx_packet(1'b1, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1), 1'b0, '0);
    // With the transmitter busy the reply is held; the next packet requests
    // either see busy again or release the held reply.
    add_row(rx_packet(1'b0, {8'h00, ArpOpRequest}, PeerMacB, PeerIpB, LocalIp1), 1'b1,
            status_res(1'b0, 1'b1, 1'b0, '0));
    add_row(rx_packet(1'b0, {8'h00, ArpOpRequest}, PeerMacA, PeerIpA, LocalIp1), 1'b1,
            status_res(1'b0, 1'b0, 1'b0, '0));
    add_row(rx_packet(1'b1, {8'h00, ArpOpReply}, PeerMacA, PeerIpA, 32'h0), 1'b0, '0);
    // Resolve while busy, then on and off our subnet.
    add_row(query(KindResolve, 1'b0, 32'hC0A8_0142), 1'b1,
            status_res(1'b0, 1'b0, 1'b0, '0));
    add_row(query(KindResolve, 1'b1, 32'hC0A8_0142), 1'b0, '0);
    add_row(query(KindResolve, 1'b1, 32'h0808_0808), 1'b0, '0);
    // The gateway answers; a check for any address then resolves through it.
    add_row(rx_packet(1'b1, {8'h00, ArpOpReply}, GwMac, Gw1, LocalIp1), 1'b1,
            status_res(1'b1, 1'b1, 1'b0, '0));
    add_row(query(KindCheck, 1'b1, 32'h0A00_0001), 1'b0, '0);
    // Extremes: all-ones addresses and opcode high bytes that must be ignored.
    it         = rx_packet(1'b1, {8'hFF, ArpOpReply}, '1, '1, LocalIp1);
    it.hw_type = 16'hFF01;
    add_row(it, 1'b1, status_res(1'b1, 1'b1, 1'b0, '0));
    add_row(query(KindCheck, 1'b1, '1), 1'b1, status_res(1'b1, 1'b0, 1'b1, '1));
    add_row(rx_packet(1'b1, {8'hFF, ArpOpRequest}, '0, '0, LocalIp1), 1'b0, '0);
    add_row(query(KindResolve, 1'b1, '1), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (r == 2) begin
        drain_results();
        apply_config(LocalIp1, Mask1, Gw1, Mac1);
      end
      send_request(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases, each under its own register settings, the extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        drain_results();
        case (ph)
          1: apply_config('0, '1, NoGateway, '0);
          2: apply_config('1, '0, '1, '1);
          3: apply_config($urandom, 32'hFFFF_0000, $urandom, {16'($urandom), 32'($urandom)});
          default: apply_config($urandom, $urandom, $urandom,
                                {16'($urandom), 32'($urandom)});
        endcase
      end
      for (int n = 0; n < RandomPerPhase; n++) begin
        // Early in the first phase the receiver stops for a long while and
        // the sender keeps offering until the block pushes back.
        if (ph == 0 && n == 20) hold_req = 1'b1;
        send_request(random_request(), 1'b0, '0);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
